### design/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg: shared types and helpers for the midpoint line rasterizer
// Holds coordinate and decision widths, request/pixel/state records and
// the opcode codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS = 12;
    localparam int COLOR_BITS = 4;
    // Decision needs sign plus headroom for minor - major/2 and its updates
    localparam int DEC_EXT    = 3;
    localparam int DEC_BITS   = COORD_BITS + DEC_EXT;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [COORD_BITS-1:0]      coord_t;
    typedef logic [COLOR_BITS-1:0]      color_t;
    typedef logic signed [DEC_BITS-1:0] dec_t;

    typedef struct packed {
        logic   opcode;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t pen_color;
    } req_t;

    typedef struct packed {
        coord_t pixel_x;
        coord_t pixel_y;
        color_t pixel_color;
        logic   pixel_valid;
        logic   last_pixel;
    } pixel_t;

    typedef struct packed {
        coord_t cur_x;
        coord_t cur_y;
        coord_t stop_major;
        coord_t abs_major;
        coord_t abs_minor;
        dec_t   decision;
        logic   x_is_major;
        logic   step_x_neg;
        logic   step_y_neg;
        color_t line_color;
        logic   busy;
    } line_state_t;

    function automatic coord_t move_one(coord_t v, logic neg);
        if (neg)
        begin
            return v - COORD_BITS'(1);
        end
        return v + COORD_BITS'(1);
    endfunction

    // Zero-extend a coordinate into the signed decision range
    function automatic dec_t ext_dec(coord_t v);
        return dec_t'({{DEC_EXT{1'b0}}, v});
    endfunction

endpackage

`default_nettype wire

### design/mlr_req_if.sv
// ----------------------------------------------------------------------------
// mlr_req_if: request channel of the line rasterizer
// Valid/ready handshake with start and step request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlr_req_if;
    logic            valid;
    logic            ready;
    logic            opcode;
    mlr_pkg::coord_t start_x;
    mlr_pkg::coord_t start_y;
    mlr_pkg::coord_t end_x;
    mlr_pkg::coord_t end_y;
    mlr_pkg::color_t pen_color;

    modport source (
        output valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        input  ready
    );

    modport sink (
        input  valid, opcode, start_x, start_y, end_x, end_y, pen_color,
        output ready
    );
endinterface

`default_nettype wire

### design/mlr_pix_if.sv
// ----------------------------------------------------------------------------
// mlr_pix_if: pixel channel of the line rasterizer
// Valid/ready handshake carrying one emitted pixel per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlr_pix_if;
    logic            valid;
    logic            ready;
    mlr_pkg::coord_t pixel_x;
    mlr_pkg::coord_t pixel_y;
    mlr_pkg::color_t pixel_color;
    logic            pixel_valid;
    logic            last_pixel;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, pixel_valid, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

### design/mlr_step.sv
// ----------------------------------------------------------------------------
// mlr_step: one rasterizer update
// Computes the next line state and the emitted pixel for one request.
// ----------------------------------------------------------------------------
`default_nettype none

module mlr_step (
    input  mlr_pkg::req_t        req,
    input  mlr_pkg::line_state_t st,
    output mlr_pkg::line_state_t st_next,
    output mlr_pkg::pixel_t      pix
);

    logic            sx_neg;
    logic            sy_neg;
    mlr_pkg::coord_t adx;
    mlr_pkg::coord_t ady;
    logic            xmaj;
    mlr_pkg::coord_t s_major;
    mlr_pkg::coord_t s_minor;
    logic            minor_moves;
    mlr_pkg::coord_t nx;
    mlr_pkg::coord_t ny;
    mlr_pkg::coord_t major_now;

    // Start: octant setup
    assign sx_neg  = req.end_x < req.start_x;
    assign sy_neg  = req.end_y < req.start_y;
    assign adx     = sx_neg ? (req.start_x - req.end_x) : (req.end_x - req.start_x);
    assign ady     = sy_neg ? (req.start_y - req.end_y) : (req.end_y - req.start_y);
    assign xmaj    = ady <= adx;
    assign s_major = xmaj ? adx : ady;
    assign s_minor = xmaj ? ady : adx;

    // Step: advance major, minor follows the decision sign
    assign minor_moves = !st.decision[mlr_pkg::DEC_BITS-1];
    assign nx = (st.x_is_major || minor_moves) ?
                mlr_pkg::move_one(st.cur_x, st.step_x_neg) : st.cur_x;
    assign ny = (!st.x_is_major || minor_moves) ?
                mlr_pkg::move_one(st.cur_y, st.step_y_neg) : st.cur_y;
    assign major_now = st.x_is_major ? nx : ny;

    always_comb
    begin
        st_next = st;
        pix     = '0;
        if (req.opcode == mlr_pkg::OP_START)
        begin
            st_next.step_x_neg = sx_neg;
            st_next.step_y_neg = sy_neg;
            st_next.x_is_major = xmaj;
            st_next.abs_major  = s_major;
            st_next.abs_minor  = s_minor;
            st_next.stop_major = xmaj ? req.end_x : req.end_y;
            st_next.decision   = mlr_pkg::ext_dec(s_minor)
                               - mlr_pkg::ext_dec(s_major >> 1);
            st_next.cur_x      = req.start_x;
            st_next.cur_y      = req.start_y;
            st_next.line_color = req.pen_color;
            st_next.busy       = s_major != '0;
            pix.pixel_x        = req.start_x;
            pix.pixel_y        = req.start_y;
            pix.pixel_color    = req.pen_color;
            pix.pixel_valid    = 1'b1;
            pix.last_pixel     = s_major == '0;
        end
        else if (st.busy)
        begin
            st_next.decision = minor_moves ?
                st.decision + mlr_pkg::ext_dec(st.abs_minor) - mlr_pkg::ext_dec(st.abs_major) :
                st.decision + mlr_pkg::ext_dec(st.abs_minor);
            st_next.cur_x   = nx;
            st_next.cur_y   = ny;
            st_next.busy    = major_now != st.stop_major;
            pix.pixel_x     = nx;
            pix.pixel_y     = ny;
            pix.pixel_color = st.line_color;
            pix.pixel_valid = 1'b1;
            pix.last_pixel  = major_now == st.stop_major;
        end
    end

endmodule

`default_nettype wire

### design/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer: eight-octant midpoint line pixel generator
// Pipeline: an accepted request lands in the input reg, and its pixel is then
// registered in the result reg before it is offered on the pixel channel.
// Throughput: one request per cycle while the pixel sink keeps taking results;
// the decision add/compare sets the path.
// Reset: rst_n low clears handshake valids and line state; block comes up idle.
`default_nettype none

module midpoint_line_rasterizer (
    input  wire          clk,
    input  wire          rst_n,
    mlr_req_if.sink      req,
    mlr_pix_if.source    pix
);

    // Input register: holds one accepted request
    logic                 in_valid_reg;
    mlr_pkg::req_t        in_reg;

    // Line state, updated when the held request advances
    mlr_pkg::line_state_t state_reg;
    mlr_pkg::line_state_t state_next;

    // Result register: holds the pixel until the sink takes it
    logic                 out_valid_reg;
    mlr_pkg::pixel_t      out_reg;
    mlr_pkg::pixel_t      out_next;

    logic                 adv;

    // Advance the held request when the result slot is empty or being drained
    assign adv       = in_valid_reg && (!out_valid_reg || pix.ready);
    // Accept a new request whenever the input slot frees up this cycle
    assign req.ready = !in_valid_reg || adv;

    mlr_step u_step (
        .req     (in_reg),
        .st      (state_reg),
        .st_next (state_next),
        .pix     (out_next)
    );

    // Input stage: control reset, payload captured on accept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg.opcode    <= req.opcode;
            in_reg.start_x   <= req.start_x;
            in_reg.start_y   <= req.start_y;
            in_reg.end_x     <= req.end_x;
            in_reg.end_y     <= req.end_y;
            in_reg.pen_color <= req.pen_color;
        end
    end

    // Line state: one update per advanced request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (adv)
        begin
            state_reg <= state_next;
        end
    end

    // Result stage: valid drops when taken with nothing new behind it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= out_next;
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_reg.pixel_x;
    assign pix.pixel_y     = out_reg.pixel_y;
    assign pix.pixel_color = out_reg.pixel_color;
    assign pix.pixel_valid = out_reg.pixel_valid;
    assign pix.last_pixel  = out_reg.last_pixel;

    // A step with no line running yields an empty result
    a_idle_step_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && in_reg.opcode == mlr_pkg::OP_STEP && !state_reg.busy)
        |=> (out_valid_reg && !out_reg.pixel_valid && !out_reg.last_pixel))
        else $error("idle step produced a pixel");

    // The last flag marks exactly the result that ends the line
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        adv |=> (out_reg.last_pixel == (out_reg.pixel_valid && !state_reg.busy)))
        else $error("last_pixel out of step with line state");

    // Line state only moves when a request advances
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(state_reg))
        else $error("line state changed without a request");

    // A stalled result keeps its payload
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pix.ready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled pixel changed");

endmodule

`default_nettype wire

### dv/tb_midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// tb_midpoint_line_rasterizer: self-checking bench for the line rasterizer
// Drives start and step requests, predicts every pixel from a behavioral
// copy of the midpoint walk and compares each returned pixel field by field.
// ----------------------------------------------------------------------------

module tb_midpoint_line_rasterizer;

    localparam int COORD_MAX   = (1 << mlr_pkg::COORD_BITS) - 1;
    localparam int QUIET_LIMIT = 3000;  // cycles with no handshake on either side
    localparam int TAIL_CYCLES = 8;     // idle time after the last pixel returns
    localparam int HOLD_CYCLES = 200;   // long receiver hold-off
    localparam int ITEM_TARGET = 800;
    localparam int MAX_REPORTS = 60;

    // One queued request, optionally held back until all pixels are back
    typedef struct packed {
        mlr_pkg::req_t fields;
        logic          drain_first;
    } line_cmd_t;

    logic clk;
    logic rst_n;

    mlr_req_if req ();
    mlr_pix_if pix ();

    midpoint_line_rasterizer i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .pix   (pix)
    );

    line_cmd_t       cmd_queue [$];
    mlr_pkg::pixel_t pixel_expect [$];
    line_cmd_t       next_cmd;

    int unsigned n_total;
    int unsigned n_popped;
    int unsigned n_accepted;
    int unsigned n_errors;
    int unsigned quiet_cycles;
    int unsigned hold_left;
    bit          hold_done;

    // Behavioral line state, mirrors the block after reset
    mlr_pkg::coord_t ln_x;
    mlr_pkg::coord_t ln_y;
    mlr_pkg::coord_t ln_stop;
    mlr_pkg::coord_t ln_major;
    mlr_pkg::coord_t ln_minor;
    mlr_pkg::dec_t   ln_dec;
    logic            ln_x_major;
    logic            ln_x_back;
    logic            ln_y_back;
    logic            ln_active;
    mlr_pkg::color_t ln_color;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // ------------------------------------------------------------------------
    // Pixel prediction
    // ------------------------------------------------------------------------

    function automatic mlr_pkg::coord_t step_toward(mlr_pkg::coord_t v, logic back);
        return back ? v - 1'b1 : v + 1'b1;
    endfunction

    // Walk one request through the midpoint line and queue the pixel it yields
    task automatic predict_pixel(input mlr_pkg::req_t r);
        mlr_pkg::pixel_t p;
        mlr_pkg::coord_t dx;
        mlr_pkg::coord_t dy;
        logic            minor_moves;
        p = '0;
        if (r.opcode == mlr_pkg::OP_START)
        begin
            // Latch the octant: direction per axis, then pick the major axis
            ln_x_back  = r.end_x < r.start_x;
            ln_y_back  = r.end_y < r.start_y;
            dx         = ln_x_back ? r.start_x - r.end_x : r.end_x - r.start_x;
            dy         = ln_y_back ? r.start_y - r.end_y : r.end_y - r.start_y;
            ln_x_major = dy <= dx;
            if (ln_x_major)
            begin
                ln_major = dx;
                ln_minor = dy;
                ln_stop  = r.end_x;
            end
            else
            begin
                ln_major = dy;
                ln_minor = dx;
                ln_stop  = r.end_y;
            end
            ln_dec    = mlr_pkg::dec_t'(int'(ln_minor) - int'(ln_major >> 1));
            ln_x      = r.start_x;
            ln_y      = r.start_y;
            ln_color  = r.pen_color;
            // A zero-length line is done on its first pixel
            ln_active = ln_major != '0;
            p.pixel_x     = ln_x;
            p.pixel_y     = ln_y;
            p.pixel_color = ln_color;
            p.pixel_valid = 1'b1;
            p.last_pixel  = !ln_active;
        end
        else if (ln_active)
        begin
            // Non-negative decision moves the minor axis as well
            minor_moves = ln_dec >= 0;
            if (minor_moves)
            begin
                ln_dec = mlr_pkg::dec_t'(int'(ln_dec) + int'(ln_minor) - int'(ln_major));
            end
            else
            begin
                ln_dec = mlr_pkg::dec_t'(int'(ln_dec) + int'(ln_minor));
            end
            if (ln_x_major)
            begin
                ln_x = step_toward(ln_x, ln_x_back);
                if (minor_moves)
                begin
                    ln_y = step_toward(ln_y, ln_y_back);
                end
                ln_active = ln_x != ln_stop;
            end
            else
            begin
                ln_y = step_toward(ln_y, ln_y_back);
                if (minor_moves)
                begin
                    ln_x = step_toward(ln_x, ln_x_back);
                end
                ln_active = ln_y != ln_stop;
            end
            p.pixel_x     = ln_x;
            p.pixel_y     = ln_y;
            p.pixel_color = ln_color;
            p.pixel_valid = 1'b1;
            p.last_pixel  = !ln_active;
        end
        // A step with no line running yields an all-zero, invalid pixel
        pixel_expect.push_back(p);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic push_cmd(input logic op, input mlr_pkg::coord_t sx,
                            input mlr_pkg::coord_t sy, input mlr_pkg::coord_t ex,
                            input mlr_pkg::coord_t ey, input mlr_pkg::color_t color,
                            input logic drain);
        line_cmd_t c;
        c.fields.opcode    = op;
        c.fields.start_x   = sx;
        c.fields.start_y   = sy;
        c.fields.end_x     = ex;
        c.fields.end_y     = ey;
        c.fields.pen_color = color;
        c.drain_first      = drain;
        cmd_queue.push_back(c);
    endtask

    // Step requests carry random junk in the fields the block ignores
    task automatic push_steps(input int unsigned count);
        repeat (count)
        begin
            push_cmd(mlr_pkg::OP_STEP,
                     mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom),
                     mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom),
                     mlr_pkg::color_t'($urandom), 1'b0);
        end
    endtask

    task automatic push_line(input mlr_pkg::coord_t sx, input mlr_pkg::coord_t sy,
                             input mlr_pkg::coord_t ex, input mlr_pkg::coord_t ey,
                             input mlr_pkg::color_t color,
                             input int unsigned steps, input logic drain);
        push_cmd(mlr_pkg::OP_START, sx, sy, ex, ey, color, drain);
        push_steps(steps);
    endtask

    // Number of steps from start to end point: the larger axis delta
    function automatic int unsigned line_length(mlr_pkg::coord_t sx, mlr_pkg::coord_t sy,
                                                mlr_pkg::coord_t ex, mlr_pkg::coord_t ey);
        int adx;
        int ady;
        adx = (int'(ex) > int'(sx)) ? int'(ex) - int'(sx) : int'(sx) - int'(ex);
        ady = (int'(ey) > int'(sy)) ? int'(ey) - int'(sy) : int'(sy) - int'(ey);
        return (adx > ady) ? adx : ady;
    endfunction

    // Offset a coordinate, clamped to the coordinate range
    function automatic mlr_pkg::coord_t offset_coord(mlr_pkg::coord_t base, int delta);
        int v;
        v = int'(base) + delta;
        if (v < 0)
        begin
            v = 0;
        end
        if (v > COORD_MAX)
        begin
            v = COORD_MAX;
        end
        return mlr_pkg::coord_t'(v);
    endfunction

    // Split the run in thirds: sender light / receiver heavy, swapped, then none
    function automatic int unsigned load_phase();
        return (n_popped * 3) / (n_total + 1);
    endfunction

    function automatic int unsigned idle_pct(input bit receiver);
        case (load_phase())
            0:       return receiver ? 70 : 15;
            1:       return receiver ? 15 : 70;
            default: return 0;
        endcase
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
            begin
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Request driver: log accepted requests, then offer the next one
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req.valid     <= 1'b0;
            req.opcode    <= mlr_pkg::OP_START;
            req.start_x   <= '0;
            req.start_y   <= '0;
            req.end_x     <= '0;
            req.end_y     <= '0;
            req.pen_color <= '0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                predict_pixel({req.opcode, req.start_x, req.start_y, req.end_x,
                               req.end_y, req.pen_color});
                n_accepted++;
            end
            // Hold the current request while it is offered and not taken
            if (!req.valid || req.ready)
            begin
                if (cmd_queue.size() == 0
                    || (cmd_queue[0].drain_first && pixel_expect.size() != 0)
                    || $urandom_range(0, 99) < idle_pct(1'b0))
                begin
                    req.valid <= 1'b0;
                end
                else
                begin
                    next_cmd = cmd_queue.pop_front();
                    n_popped++;
                    req.valid     <= 1'b1;
                    req.opcode    <= next_cmd.fields.opcode;
                    req.start_x   <= next_cmd.fields.start_x;
                    req.start_y   <= next_cmd.fields.start_y;
                    req.end_x     <= next_cmd.fields.end_x;
                    req.end_y     <= next_cmd.fields.end_y;
                    req.pen_color <= next_cmd.fields.pen_color;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel receiver: random stalls plus one long hold-off late in the run,
    // while the sender keeps pushing so the block backs up into its input
    // ------------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (!hold_done && n_popped >= (n_total * 5) / 6)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                pix.ready <= 1'b0;
            end
            else
            begin
                pix.ready <= $urandom_range(0, 99) >= idle_pct(1'b1);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Pixel monitor: match each accepted pixel against the oldest prediction
    // ------------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (rst_n && pix.valid && pix.ready)
        begin
            if (pixel_expect.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                begin
                    $error("pixel with no request pending: x %0d y %0d",
                           pix.pixel_x, pix.pixel_y);
                end
            end
            else
            begin
                check_field("pixel_x", 16'(pixel_expect[0].pixel_x), 16'(pix.pixel_x));
                check_field("pixel_y", 16'(pixel_expect[0].pixel_y), 16'(pix.pixel_y));
                check_field("pixel_color", 16'(pixel_expect[0].pixel_color),
                            16'(pix.pixel_color));
                check_field("pixel_valid", 16'(pixel_expect[0].pixel_valid),
                            16'(pix.pixel_valid));
                check_field("last_pixel", 16'(pixel_expect[0].last_pixel),
                            16'(pix.last_pixel));
                pixel_expect.pop_front();
            end
        end
    end

    // Drop the run if neither channel moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req.valid && req.ready) || (pix.valid && pix.ready))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("== FAIL ==");
                    $finish;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Reset, stimulus build and end of run
    // ------------------------------------------------------------------------

    initial
    begin
        mlr_pkg::coord_t sx;
        mlr_pkg::coord_t sy;
        mlr_pkg::coord_t ex;
        mlr_pkg::coord_t ey;
        int              lx;
        int              ly;
        int unsigned     reach;
        int unsigned     len;
        int unsigned     roll;
        logic            drain;

        rst_n         = 1'b0;
        req.valid     = 1'b0;
        req.opcode    = mlr_pkg::OP_START;
        req.start_x   = '0;
        req.start_y   = '0;
        req.end_x     = '0;
        req.end_y     = '0;
        req.pen_color = '0;
        pix.ready     = 1'b0;

        n_popped     = 0;
        n_accepted   = 0;
        n_errors     = 0;
        quiet_cycles = 0;
        hold_done    = 1'b0;
        hold_left    = 0;

        ln_x       = '0;
        ln_y       = '0;
        ln_stop    = '0;
        ln_major   = '0;
        ln_minor   = '0;
        ln_dec     = '0;
        ln_x_major = 1'b0;
        ln_x_back  = 1'b0;
        ln_y_back  = 1'b0;
        ln_active  = 1'b0;
        ln_color   = '0;

        // Directed: step with no line, all-ones junk in the ignored fields
        push_cmd(mlr_pkg::OP_STEP, '1, '1, '1, '1, '1, 1'b0);
        // Zero-length line at the origin: one pixel, flagged last
        push_line('0, '0, '0, '0, '0, 0, 1'b0);
        // Full-range diagonal, abandoned by a new start while still running
        push_line('0, '0, '1, '1, '1, 2, 1'b0);
        // Full-range anti-diagonal, also cut short
        push_line('1, '0, '0, '1, '1, 1, 1'b0);
        // Shallow line walking back from the top corner, run to its end
        push_line('1, '1, mlr_pkg::coord_t'(COORD_MAX - 5),
                  mlr_pkg::coord_t'(COORD_MAX - 2), 4'd9, 5, 1'b0);
        // Steep line with mixed decisions, plus one step past the end point
        push_line(12'd10, 12'd10, 12'd12, 12'd17, 4'd6, 8, 1'b0);
        // Vertical line walking toward zero
        push_line(12'd20, 12'd30, 12'd20, 12'd26, 4'd3, 4, 1'b0);

        // Random: mostly complete short lines anywhere on the grid, some long
        // ones cut short, some stray steps; the first line waits for a drain
        drain = 1'b1;
        while (cmd_queue.size() < ITEM_TARGET)
        begin
            roll = $urandom_range(0, 99);
            sx   = mlr_pkg::coord_t'($urandom);
            sy   = mlr_pkg::coord_t'($urandom);
            if (roll < 8)
            begin
                push_steps($urandom_range(1, 3));
            end
            else if (roll < 13)
            begin
                push_line(sx, sy, mlr_pkg::coord_t'($urandom), mlr_pkg::coord_t'($urandom),
                          mlr_pkg::color_t'($urandom), $urandom_range(0, 30), 1'b0);
            end
            else
            begin
                reach = ($urandom_range(0, 19) == 0) ? 200 : 12;
                lx    = $urandom_range(0, reach);
                case ($urandom_range(0, 7))
                    0:       ly = lx;
                    1:       ly = 0;
                    2:       ly = lx + 1;
                    default: ly = $urandom_range(0, reach);
                endcase
                ex  = offset_coord(sx, $urandom_range(0, 1) ? -lx : lx);
                ey  = offset_coord(sy, $urandom_range(0, 1) ? -ly : ly);
                len = line_length(sx, sy, ex, ey);
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    len = $urandom_range(0, len);
                end
                else if (roll < 20)
                begin
                    len = len + $urandom_range(1, 3);
                end
                push_line(sx, sy, ex, ey, mlr_pkg::color_t'($urandom), len, drain);
                drain = $urandom_range(0, 49) == 0;
            end
        end
        n_total = cmd_queue.size();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Wait for every request to go out and every pixel to come back
        @(posedge clk);
        while (cmd_queue.size() != 0 || req.valid || pixel_expect.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (n_errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
